// ----- src/bma_pkg.sv -----
// Shared constants, register codes and controller/datapath link types.
package bma_pkg;

  // Default values for the top-level parameters
  localparam int MAX_LENGTH_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_GUESS = 2'd1;

  // Window length after reset, before any clamp to the maximum
  localparam int WINDOW_LENGTH_RESET = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture sample, write ring slot, read oldest slot
    logic update;  // fold sample into running sum, advance head
    logic load;    // load divider with |sum|
    logic step;    // one quotient bit
    logic finish;  // apply sign, fill output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // current divider step produces the last bit
  } dp_status_t;

endpackage

// ----- src/bma_stream_if.sv -----
// Valid/ready stream interfaces for the sample and average channels.
interface bma_sample_if
  import bma_pkg::*;
#(
  parameter int W = SAMPLE_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bma_average_if
  import bma_pkg::*;
#(
  parameter int W = SAMPLE_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

// ----- src/boxcar_moving_average.sv -----
// Boxcar moving average: top level joining sequencer and datapath.
//
// Usage:
//   sample_i is a valid/ready sink; one signed sample per transaction.
//   average_o is a valid/ready source; one average per accepted sample,
//   the window sum divided by the window length, truncated toward zero.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set window_length
//   (index 0, clamped to 1..MAX_LENGTH) or initial_guess (index 1); either
//   write restarts the window as if every slot held initial_guess.
// Flow:
//   A sample is taken only when the block is idle, so a new sample waits
//   until the previous one has passed the update, load, divide and finish
//   states. The serial divider produces one quotient bit per cycle over
//   SUM_BITS = SAMPLE_BITS + log2(MAX_LENGTH) bits.
// Reset: window length 8 (or MAX_LENGTH if smaller), guess 0, empty window.
// Stall: the output register holds a finished average until taken; a next
//   sample is still accepted and processed, and its result waits before
//   the output stage until the register frees.
module boxcar_moving_average
  import bma_pkg::*;
#(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_BITS   = $clog2(MAX_LENGTH + 1),
  localparam int CFG_BITS   = (LEN_BITS > SAMPLE_BITS) ? LEN_BITS : SAMPLE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  bma_sample_if.sink              sample_i,
  bma_average_if.source           average_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (average_o.valid),
    .out_ready_i (average_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bma_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_i.sample),
    .average_o  (average_o.average),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  // One sample in flight: no new transaction right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while previous one in progress");

  // The sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.update, cmd.load, cmd.step, cmd.finish}))
    else $error("overlapping datapath commands");

  // A result never overwrites an unclaimed one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!average_o.valid || average_o.ready))
    else $error("output register overwritten");

  // Finishing a division presents a result next cycle
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> average_o.valid)
    else $error("finished result not presented");

endmodule

// ----- src/bma_ctrl.sv -----
// Sequencer: walks one transaction through update, divide and output.
module bma_ctrl
  import bma_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // Output register can take a new result this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result is still unclaimed
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/bma_datapath.sv -----
// Ring store, running sum, config registers and serial restoring divider.
module bma_datapath
  import bma_pkg::*;
#(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_BITS   = $clog2(MAX_LENGTH + 1),
  localparam int CFG_BITS   = (LEN_BITS > SAMPLE_BITS) ? LEN_BITS : SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  input  ctrl_cmd_t                     cmd_i,
  output dp_status_t                    status_o
);

  localparam int IDX_BITS = $clog2(MAX_LENGTH);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_LENGTH);
  localparam int CNT_BITS = $clog2(SUM_BITS);
  localparam int LEN_RST  =
    (MAX_LENGTH < WINDOW_LENGTH_RESET) ? MAX_LENGTH : WINDOW_LENGTH_RESET;

  // Ring store, no reset: a slot's read value is only used once written
  logic signed [SAMPLE_BITS-1:0] mem_q [MAX_LENGTH];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Control and config state
  logic [LEN_BITS-1:0]           len_q, len_d;
  logic signed [SAMPLE_BITS-1:0] guess_q, guess_d;
  logic [IDX_BITS-1:0]           head_q, head_d;
  logic [LEN_BITS-1:0]           fill_q, fill_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic                          neg_q;

  // Divider datapath
  logic [SUM_BITS-1:0]           quo_q;
  logic [LEN_BITS-1:0]           rem_q;
  logic signed [SAMPLE_BITS-1:0] avg_q;
  logic [LEN_BITS:0]             trial;
  logic [LEN_BITS:0]             diff;
  logic                          qbit;

  // Config decode
  logic                                cfg_len_wr, cfg_guess_wr;
  logic [LEN_BITS-1:0]                 len_wr;
  logic [LEN_BITS-1:0]                 len_cfg;
  logic signed [LEN_BITS+SAMPLE_BITS:0] restart_prod;
  logic [LEN_BITS-1:0]                 head_inc;
  logic signed [SAMPLE_BITS-1:0]       oldest;

  assign cfg_len_wr   = cfg_we_i && (cfg_idx_i == REG_WINDOW_LENGTH);
  assign cfg_guess_wr = cfg_we_i && (cfg_idx_i == REG_INITIAL_GUESS);
  assign len_wr       = cfg_data_i[LEN_BITS-1:0];

  // Clamp length to [1, MAX_LENGTH]
  always_comb begin
    if (len_wr > LEN_BITS'(MAX_LENGTH)) len_cfg = LEN_BITS'(MAX_LENGTH);
    else if (len_wr == '0)              len_cfg = LEN_BITS'(1);
    else                                len_cfg = len_wr;
  end

  assign len_d   = cfg_len_wr ? len_cfg : len_q;
  assign guess_d = cfg_guess_wr ? $signed(cfg_data_i[SAMPLE_BITS-1:0]) : guess_q;

  // Sum after a restart: length times initial guess
  assign restart_prod = $signed({1'b0, len_d}) * guess_d;

  // Oldest value leaving the window: guess until the ring has filled
  assign oldest   = (fill_q < len_q) ? guess_q : rd_q;
  assign head_inc = LEN_BITS'(head_q) + LEN_BITS'(1);

  // Divider step: shift in next dividend bit, trial subtract
  assign trial = {rem_q, quo_q[SUM_BITS-1]};
  assign diff  = trial - {1'b0, len_q};
  assign qbit  = (trial >= {1'b0, len_q});

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    if (cfg_len_wr || cfg_guess_wr) begin
      head_d = '0;
      fill_d = '0;
      sum_d  = restart_prod[SUM_BITS-1:0];
    end else if (cmd_i.update) begin
      sum_d = sum_q + SUM_BITS'(sample_q) - SUM_BITS'(oldest);
      if (fill_q < len_q) fill_d = fill_q + LEN_BITS'(1);
      head_d = (head_inc >= len_q) ? '0 : head_inc[IDX_BITS-1:0];
    end
    if (cmd_i.load)      cnt_d = '0;
    else if (cmd_i.step) cnt_d = cnt_q + CNT_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_BITS'(LEN_RST);
      guess_q <= '0;
      head_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      guess_q <= guess_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      if (cmd_i.load) neg_q <= sum_q[SUM_BITS-1];
    end
  end

  // Ring store: write new sample, read old slot at the same address
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[head_q] <= sample_i;
      rd_q          <= mem_q[head_q];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sample_q <= sample_i;
    if (cmd_i.load) begin
      quo_q <= sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[SUM_BITS-2:0], qbit};
      rem_q <= qbit ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
    end
    if (cmd_i.finish) begin
      avg_q <= neg_q ? -$signed(quo_q[SAMPLE_BITS-1:0]) : $signed(quo_q[SAMPLE_BITS-1:0]);
    end
  end

  assign status_o.div_last = (cnt_q == CNT_BITS'(SUM_BITS - 1));
  assign average_o         = avg_q;

endmodule
